// ----- rtl/ltm_pkg.sv -----
`default_nettype none
package ltm_pkg;

  localparam int LOCK_ENTRIES = 16;
  localparam int WAIT_ENTRIES = 16;

  localparam int HI_W = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int WI_W = (WAIT_ENTRIES > 1) ? $clog2(WAIT_ENTRIES) : 1;
  localparam int WC_W = $clog2(WAIT_ENTRIES + 1);
  localparam int WX_W = WI_W + 1;

  localparam int KEY_W = 64;
  localparam int CLIENT_W = 32;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    KIND_GRANT     = 2'd0,
    KIND_RELEASED  = 2'd1,
    KIND_NOT_OWNED = 2'd2,
    KIND_FULL      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    HT_NOP,
    HT_CLAIM,
    HT_OWNER,
    HT_FREE
  } ht_op_t;

  typedef struct packed {
    ht_op_t            op;
    logic [HI_W-1:0]   idx;
  } ht_ctl_t;

  typedef struct packed {
    logic              wr_en;
    logic [WI_W-1:0]   wr_idx;
    logic              inc;
    logic              dec;
  } wq_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/ltm_held_tbl.sv -----
`default_nettype none
module ltm_held_tbl
  import ltm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [HI_W-1:0]     rd_idx,
  output logic                     rd_valid,
  output logic [KEY_W-1:0]         rd_key,
  output logic [CLIENT_W-1:0]      rd_owner,
  input  wire ht_ctl_t             ctl,
  input  wire logic [KEY_W-1:0]    wr_key,
  input  wire logic [CLIENT_W-1:0] wr_owner
);

  logic [LOCK_ENTRIES-1:0] valid;
  logic [KEY_W-1:0]        keys   [LOCK_ENTRIES];
  logic [CLIENT_W-1:0]     owners [LOCK_ENTRIES];

  assign rd_valid = valid[rd_idx];
  assign rd_key   = keys[rd_idx];
  assign rd_owner = owners[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      unique case (ctl.op)
        HT_CLAIM: valid[ctl.idx] <= 1'b1;
        HT_FREE:  valid[ctl.idx] <= 1'b0;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == HT_CLAIM) begin
      keys[ctl.idx] <= wr_key;
    end
    if (ctl.op == HT_CLAIM || ctl.op == HT_OWNER) begin
      owners[ctl.idx] <= wr_owner;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ltm_wait_q.sv -----
`default_nettype none
module ltm_wait_q
  import ltm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [WI_W-1:0]     rd_idx,
  output logic [KEY_W-1:0]         rd_key,
  output logic [CLIENT_W-1:0]      rd_client,
  input  wire wq_ctl_t             ctl,
  input  wire logic [KEY_W-1:0]    wr_key,
  input  wire logic [CLIENT_W-1:0] wr_client,
  output logic [WC_W-1:0]          count
);

  // entries [0, count) are live, oldest at index 0
  logic [KEY_W-1:0]    keys    [WAIT_ENTRIES];
  logic [CLIENT_W-1:0] clients [WAIT_ENTRIES];

  assign rd_key    = keys[rd_idx];
  assign rd_client = clients[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      priority if (ctl.inc) begin
        count <= count + 1'b1;
      end else if (ctl.dec) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      keys[ctl.wr_idx]    <= wr_key;
      clients[ctl.wr_idx] <= wr_client;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lock_table_manager_core.sv -----
// Lock table manager. Each request acquires or releases a 64-bit lock key for
// a 32-bit client. A sequencer walks the held table and then the waiting list
// one entry per cycle through a single shared key comparator; a release that
// hands the lock to a waiter also compacts the waiting list one entry per
// cycle. in_ready is low while a request is in progress; results sit in an
// output register, so a new request can be taken while the last result still
// waits on out_ready. A release handed on to a waiter yields two results:
// released to the owner (last low), then granted to the oldest waiter on that
// key (last high). A queued acquire yields none.
`default_nettype none
module lock_table_manager_core
  import ltm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                cmd,
  input  wire logic [CLIENT_W-1:0] client,
  input  wire logic [KEY_W-1:0]    lock_key,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               kind,
  output logic [CLIENT_W-1:0]      who,
  output logic [KEY_W-1:0]         which_lock,
  output logic                     last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_H,
    S_DECIDE,
    S_SCAN_W,
    S_SHIFT,
    S_EMIT_A,
    S_EMIT_B
  } state_t;

  state_t              state;
  logic                cmd_r;
  logic [CLIENT_W-1:0] client_r;
  logic [KEY_W-1:0]    key_r;
  logic [CLIENT_W-1:0] next_client;
  kind_t               kind_r;
  logic                last_r;
  logic [HI_W-1:0]     hidx;
  logic [HI_W-1:0]     free_idx;
  logic                hit;
  logic                free_ok;
  logic [WI_W-1:0]     widx;

  logic                ht_rd_valid;
  logic [KEY_W-1:0]    ht_rd_key;
  logic [CLIENT_W-1:0] ht_rd_owner;
  ht_ctl_t             ht_ctl;
  logic [CLIENT_W-1:0] ht_wr_owner;

  logic [WI_W-1:0]     wq_rd_idx;
  logic [KEY_W-1:0]    wq_rd_key;
  logic [CLIENT_W-1:0] wq_rd_client;
  wq_ctl_t             wq_ctl;
  logic [KEY_W-1:0]    wq_wr_key;
  logic [CLIENT_W-1:0] wq_wr_client;
  logic [WC_W-1:0]     wcnt;

  logic [KEY_W-1:0]    cmp_b;
  logic                key_eq;
  logic                owner_eq;
  logic                w_more;
  logic                wq_full;
  logic                out_free;
  logic                emit_fire;
  logic                h_last;

  ltm_held_tbl u_held (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (hidx),
    .rd_valid (ht_rd_valid),
    .rd_key   (ht_rd_key),
    .rd_owner (ht_rd_owner),
    .ctl      (ht_ctl),
    .wr_key   (key_r),
    .wr_owner (ht_wr_owner)
  );

  ltm_wait_q u_wait (
    .clk       (clk),
    .rst       (rst),
    .rd_idx    (wq_rd_idx),
    .rd_key    (wq_rd_key),
    .rd_client (wq_rd_client),
    .ctl       (wq_ctl),
    .wr_key    (wq_wr_key),
    .wr_client (wq_wr_client),
    .count     (wcnt)
  );

  // shared key comparator
  assign cmp_b     = (state == S_SCAN_H) ? ht_rd_key : wq_rd_key;
  assign key_eq    = (key_r == cmp_b);
  assign owner_eq  = (ht_rd_owner == client_r);
  assign w_more    = (({1'b0, widx} + 1'b1) < WX_W'(wcnt));
  assign wq_full   = (wcnt == WC_W'(WAIT_ENTRIES));
  assign out_free  = !out_valid || out_ready;
  assign emit_fire = out_free && (state == S_EMIT_A || state == S_EMIT_B);
  assign h_last    = (hidx == HI_W'(LOCK_ENTRIES - 1));
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    ht_ctl      = '{op: HT_NOP, idx: hidx};
    ht_wr_owner = client_r;
    wq_ctl      = '{wr_en: 1'b0, wr_idx: widx, inc: 1'b0, dec: 1'b0};
    wq_rd_idx   = widx;
    wq_wr_key   = key_r;
    wq_wr_client = client_r;
    unique case (state)
      S_DECIDE: begin
        if (cmd_r == CMD_ACQUIRE) begin
          if (!hit && free_ok) begin
            ht_ctl = '{op: HT_CLAIM, idx: free_idx};
          end else if (hit && !wq_full) begin
            wq_ctl = '{wr_en: 1'b1, wr_idx: wcnt[WI_W-1:0], inc: 1'b1, dec: 1'b0};
          end
        end else if (hit && owner_eq && wcnt == '0) begin
          ht_ctl = '{op: HT_FREE, idx: hidx};
        end
      end
      S_SCAN_W: begin
        if (key_eq) begin
          ht_ctl      = '{op: HT_OWNER, idx: hidx};
          ht_wr_owner = wq_rd_client;
        end else if (!w_more) begin
          ht_ctl = '{op: HT_FREE, idx: hidx};
        end
      end
      S_SHIFT: begin
        wq_rd_idx    = widx + 1'b1;
        wq_wr_key    = wq_rd_key;
        wq_wr_client = wq_rd_client;
        if (w_more) begin
          wq_ctl = '{wr_en: 1'b1, wr_idx: widx, inc: 1'b0, dec: 1'b0};
        end else begin
          wq_ctl = '{wr_en: 1'b0, wr_idx: widx, inc: 1'b0, dec: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r    <= cmd;
            client_r <= client;
            key_r    <= lock_key;
            hidx     <= '0;
            hit      <= 1'b0;
            free_ok  <= 1'b0;
            state    <= S_SCAN_H;
          end
        end
        S_SCAN_H: begin
          if (ht_rd_valid && key_eq) begin
            hit   <= 1'b1;
            state <= S_DECIDE;
          end else begin
            if (!ht_rd_valid && !free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= hidx;
            end
            if (h_last) begin
              state <= S_DECIDE;
            end else begin
              hidx <= hidx + 1'b1;
            end
          end
        end
        S_DECIDE: begin
          last_r <= 1'b1;
          if (cmd_r == CMD_ACQUIRE) begin
            if (!hit) begin
              kind_r <= free_ok ? KIND_GRANT : KIND_FULL;
              state  <= S_EMIT_A;
            end else if (wq_full) begin
              kind_r <= KIND_FULL;
              state  <= S_EMIT_A;
            end else begin
              state <= S_IDLE;
            end
          end else if (!hit || !owner_eq) begin
            kind_r <= KIND_NOT_OWNED;
            state  <= S_EMIT_A;
          end else if (wcnt == '0) begin
            kind_r <= KIND_RELEASED;
            state  <= S_EMIT_A;
          end else begin
            widx  <= '0;
            state <= S_SCAN_W;
          end
        end
        S_SCAN_W: begin
          kind_r <= KIND_RELEASED;
          if (key_eq) begin
            next_client <= wq_rd_client;
            last_r      <= 1'b0;
            state       <= S_SHIFT;
          end else if (!w_more) begin
            last_r <= 1'b1;
            state  <= S_EMIT_A;
          end else begin
            widx <= widx + 1'b1;
          end
        end
        S_SHIFT: begin
          if (w_more) begin
            widx <= widx + 1'b1;
          end else begin
            state <= S_EMIT_A;
          end
        end
        S_EMIT_A: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            kind       <= kind_r;
            who        <= client_r;
            which_lock <= key_r;
            last       <= last_r;
            state      <= last_r ? S_IDLE : S_EMIT_B;
          end
        end
        S_EMIT_B: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            kind       <= KIND_GRANT;
            who        <= next_client;
            which_lock <= key_r;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- dv/lock_table_manager_core_tb.sv -----
`timescale 1ns / 100ps

module lock_table_manager_core_tb;
  import ltm_pkg::*;

  localparam int SETTLE_CYCLES = 4 * (LOCK_ENTRIES + 2 * WAIT_ENTRIES + 4);
  localparam logic [KEY_W-1:0]    KEY_MAX = '1;
  localparam logic [CLIENT_W-1:0] CLI_MAX = '1;

  typedef struct {
    logic [CLIENT_W-1:0] client;
    logic [KEY_W-1:0]    key;
  } waiter_t;

  typedef struct {
    kind_t               kind;
    logic [CLIENT_W-1:0] who;
    logic [KEY_W-1:0]    lk;
    logic                fin;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                cmd = CMD_ACQUIRE;
  logic [CLIENT_W-1:0] client = '0;
  logic [KEY_W-1:0]    lock_key = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          kind;
  logic [CLIENT_W-1:0] who;
  logic [KEY_W-1:0]    which_lock;
  logic                last;

  // predicted lock table and waiting list
  logic                lk_used  [LOCK_ENTRIES];
  logic [KEY_W-1:0]    lk_key   [LOCK_ENTRIES];
  logic [CLIENT_W-1:0] lk_owner [LOCK_ENTRIES];
  int                  held_total = 0;
  waiter_t             wait_line[$];
  reply_t              due_replies[$];

  int send_gap_pct   = 10;
  int recv_stall_pct = 56;
  int sent_count     = 0;
  int checked_count  = 0;
  int fault_count    = 0;
  int kind_tally [4] = '{0, 0, 0, 0};

  lock_table_manager_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .client     (client),
    .lock_key   (lock_key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .who        (who),
    .which_lock (which_lock),
    .last       (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void push_reply(kind_t k, logic [CLIENT_W-1:0] w,
                                     logic [KEY_W-1:0] l, logic f);
    reply_t r;
    r.kind = k;
    r.who  = w;
    r.lk   = l;
    r.fin  = f;
    due_replies.push_back(r);
  endfunction

  function automatic void apply_lock_request(logic c, logic [CLIENT_W-1:0] cl,
                                             logic [KEY_W-1:0] k);
    int h;
    int f;
    int w;
    h = -1;
    f = -1;
    w = -1;
    for (int i = 0; i < LOCK_ENTRIES; i++) begin
      if (h < 0 && lk_used[i] && lk_key[i] == k) h = i;
      if (f < 0 && !lk_used[i]) f = i;
    end
    if (c == CMD_ACQUIRE) begin
      if (h < 0) begin
        if (f < 0) begin
          push_reply(KIND_FULL, cl, k, 1'b1);
        end else begin
          lk_used[f]  = 1'b1;
          lk_key[f]   = k;
          lk_owner[f] = cl;
          held_total++;
          push_reply(KIND_GRANT, cl, k, 1'b1);
        end
      end else if (wait_line.size() >= WAIT_ENTRIES) begin
        push_reply(KIND_FULL, cl, k, 1'b1);
      end else begin
        wait_line.push_back('{client: cl, key: k});
      end
    end else if (h < 0 || lk_owner[h] != cl) begin
      push_reply(KIND_NOT_OWNED, cl, k, 1'b1);
    end else begin
      foreach (wait_line[i]) begin
        if (w < 0 && wait_line[i].key == k) w = i;
      end
      if (w >= 0) begin
        lk_owner[h] = wait_line[w].client;
        push_reply(KIND_RELEASED, cl, k, 1'b0);
        push_reply(KIND_GRANT, wait_line[w].client, k, 1'b1);
        wait_line.delete(w);
      end else begin
        lk_used[h] = 1'b0;
        held_total--;
        push_reply(KIND_RELEASED, cl, k, 1'b1);
      end
    end
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_held_slot();
    int slots[$];
    for (int i = 0; i < LOCK_ENTRIES; i++) begin
      if (lk_used[i]) slots.push_back(i);
    end
    if (slots.size() == 0) return -1;
    return slots[$urandom_range(slots.size() - 1)];
  endfunction

  task automatic send_request(input logic c, input logic [CLIENT_W-1:0] cl,
                              input logic [KEY_W-1:0] k);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    client   <= cl;
    lock_key <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_lock_request(c, cl, k);
    sent_count++;
  endtask

  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && out_valid && out_ready) begin
      checked_count++;
      kind_tally[kind]++;
      if (due_replies.size() == 0) begin
        if (fault_count < 10)
          $display("[%0t] unexpected result: kind %0d who %h lock %h last %b",
                   $time, kind, who, which_lock, last);
        fault_count++;
      end else begin
        exp_r = due_replies.pop_front();
        if (kind !== exp_r.kind || who !== exp_r.who || which_lock !== exp_r.lk ||
            last !== exp_r.fin) begin
          if (fault_count < 10)
            $display("[%0t] mismatch: exp kind %0d who %h lock %h last %b, got kind %0d who %h lock %h last %b",
                     $time, exp_r.kind, exp_r.who, exp_r.lk, exp_r.fin,
                     kind, who, which_lock, last);
          fault_count++;
        end
      end
    end
  end

  task automatic test_basic_grant_release();
    send_request(CMD_ACQUIRE, '0, '0);
    send_request(CMD_ACQUIRE, CLI_MAX, KEY_MAX);
    send_request(CMD_ACQUIRE, CLI_MAX, '0);
    send_request(CMD_ACQUIRE, '0, '0);
    send_request(CMD_ACQUIRE, CLI_MAX, '0);
    send_request(CMD_RELEASE, 32'h5, '0);
    send_request(CMD_RELEASE, '0, 64'h1234);
    send_request(CMD_RELEASE, '0, KEY_MAX);
    send_request(CMD_RELEASE, '0, '0);
    send_request(CMD_RELEASE, CLI_MAX, '0);
    send_request(CMD_RELEASE, '0, '0);
    send_request(CMD_RELEASE, CLI_MAX, '0);
    send_request(CMD_RELEASE, CLI_MAX, KEY_MAX);
    send_request(CMD_RELEASE, CLI_MAX, KEY_MAX);
    send_request(CMD_ACQUIRE, 32'h5555_5555, {4{16'hAAAA}});
    send_request(CMD_ACQUIRE, 32'hAAAA_AAAA, {4{16'h5555}});
    send_request(CMD_RELEASE, 32'h5555_5555, {4{16'hAAAA}});
    send_request(CMD_RELEASE, 32'hAAAA_AAAA, {4{16'h5555}});
  endtask

  task automatic test_lock_table_full();
    while (held_total < LOCK_ENTRIES) send_request(CMD_ACQUIRE, $urandom, rand_key());
    send_request(CMD_ACQUIRE, $urandom, rand_key());
  endtask

  task automatic test_waiting_list_full();
    int h;
    logic [KEY_W-1:0] k;
    h = pick_held_slot();
    k = lk_key[h];
    while (wait_line.size() < WAIT_ENTRIES) send_request(CMD_ACQUIRE, $urandom, k);
    send_request(CMD_ACQUIRE, $urandom, k);
    send_request(CMD_ACQUIRE, $urandom, rand_key());
    // drain: every release by its owner, handing on to each waiter in turn
    h = pick_held_slot();
    while (h >= 0) begin
      send_request(CMD_RELEASE, lk_owner[h], lk_key[h]);
      h = pick_held_slot();
    end
  endtask

  task automatic test_mixed_traffic(input int n_items);
    logic [KEY_W-1:0]    key_pool    [20];
    logic [CLIENT_W-1:0] client_pool [8];
    logic [CLIENT_W-1:0] cl;
    logic [KEY_W-1:0]    k;
    int acq_pct;
    int r;
    int h;
    acq_pct = 55;
    for (int n = 0; n < n_items; n++) begin
      if (n % 60 == 0) begin
        foreach (key_pool[i]) key_pool[i] = rand_key();
        foreach (client_pool[i]) client_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        client_pool[0] = '0;
        client_pool[1] = CLI_MAX;
        case ($urandom_range(2))
          0: acq_pct = 35;
          1: acq_pct = 55;
          default: acq_pct = 80;
        endcase
      end
      r  = $urandom_range(99);
      h  = pick_held_slot();
      cl = ($urandom_range(9) == 0) ? $urandom : client_pool[$urandom_range(7)];
      if ($urandom_range(99) < acq_pct) begin
        if (r < 15 && h >= 0) k = lk_key[h];
        else if (r < 25) k = rand_key();
        else k = key_pool[$urandom_range(19)];
        send_request(CMD_ACQUIRE, cl, k);
      end else if (r < 80 && h >= 0) begin
        send_request(CMD_RELEASE, lk_owner[h], lk_key[h]);
      end else if (r < 90 && h >= 0) begin
        send_request(CMD_RELEASE, cl, lk_key[h]);
      end else begin
        k = (r < 95) ? key_pool[$urandom_range(19)] : rand_key();
        send_request(CMD_RELEASE, cl, k);
      end
    end
  endtask

  initial begin
    foreach (lk_used[i]) lk_used[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_grant_release();
    test_lock_table_full();
    test_waiting_list_full();
    test_mixed_traffic(450);
    send_gap_pct   = 56;
    recv_stall_pct = 10;
    test_mixed_traffic(450);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_mixed_traffic(450);

    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d acquire/release requests, incl. full table, full waiting list and hand-over",
             sent_count);
    $display("Checked %0d results: %0d granted, %0d released, %0d not owned, %0d full",
             checked_count, kind_tally[KIND_GRANT], kind_tally[KIND_RELEASED],
             kind_tally[KIND_NOT_OWNED], kind_tally[KIND_FULL]);
    if (fault_count == 0 && due_replies.size() == 0) begin
      $display("lock_table_manager_core_tb OK");
    end else begin
      $display("lock_table_manager_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", due_replies.size());
    $display("lock_table_manager_core_tb NOT OK");
    $finish;
  end

endmodule
